>>> sv/pse_pkg.sv
// pse_pkg: shared types and codes for the postfix stack evaluator
// request kinds, operator codes, status codes and the controller/datapath interface
// no dependencies
`default_nettype none

package pse_pkg;

    localparam int DATA_W  = 32;
    localparam int COUNT_W = 7;

    localparam logic [DATA_W-1:0] DATA_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] DATA_ONES = 32'hFFFF_FFFF;

    // request kinds
    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_PUSH  = 2'd1;
    localparam logic [1:0] REQ_APPLY = 2'd2;

    // operator codes
    localparam logic [3:0] OP_PLUS = 4'd0;
    localparam logic [3:0] OP_NEG  = 4'd1;
    localparam logic [3:0] OP_LNOT = 4'd2;
    localparam logic [3:0] OP_BNOT = 4'd3;
    localparam logic [3:0] OP_MUL  = 4'd4;
    localparam logic [3:0] OP_DIV  = 4'd5;
    localparam logic [3:0] OP_MOD  = 4'd6;
    localparam logic [3:0] OP_ADD  = 4'd7;
    localparam logic [3:0] OP_SUB  = 4'd8;
    localparam logic [3:0] OP_SHL  = 4'd9;
    localparam logic [3:0] OP_SHR  = 4'd10;
    localparam logic [3:0] OP_AND  = 4'd11;
    localparam logic [3:0] OP_XOR  = 4'd12;
    localparam logic [3:0] OP_OR   = 4'd13;
    localparam logic [3:0] OP_LAND = 4'd14;
    localparam logic [3:0] OP_LOR  = 4'd15;

    // result status codes
    localparam logic [2:0] STATUS_OK      = 3'd0;
    localparam logic [2:0] STATUS_UNDER   = 3'd1;
    localparam logic [2:0] STATUS_OVER    = 3'd2;
    localparam logic [2:0] STATUS_DIVZERO = 3'd3;
    localparam logic [2:0] STATUS_DIVOVF  = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic div_start;
        logic commit;
    } pse_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_ok;
        logic div_busy;
    } pse_stat_t;

endpackage

`default_nettype wire

>>> sv/pse_divider.sv
// pse_divider: 32-bit signed divider, one quotient bit per cycle
// truncating quotient and remainder with the dividend's sign; uses pse_pkg
`default_nettype none

module pse_divider
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [pse_pkg::DATA_W-1:0]   dividend,
    input  wire logic [pse_pkg::DATA_W-1:0]   divisor,
    output logic                              busy,
    output logic [pse_pkg::DATA_W-1:0]        quotient,
    output logic [pse_pkg::DATA_W-1:0]        remainder
);

    localparam int DW = pse_pkg::DATA_W;
    localparam int CNT_W = $clog2(DW);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DW-1:0]    quo_reg;
    logic [DW-1:0]    rem_reg;
    logic [DW-1:0]    dvs_reg;
    logic             neg_q_reg;
    logic             neg_r_reg;

    logic [DW:0]      trial;
    logic [DW:0]      diff;
    logic [DW-1:0]    abs_dividend;
    logic [DW-1:0]    abs_divisor;

    assign abs_dividend = dividend[DW-1] ? (~dividend + 1'b1) : dividend;
    assign abs_divisor  = divisor[DW-1]  ? (~divisor + 1'b1)  : divisor;

    assign trial = {rem_reg, quo_reg[DW-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DW - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg   <= abs_dividend;
            rem_reg   <= '0;
            dvs_reg   <= abs_divisor;
            neg_q_reg <= dividend[DW-1] ^ divisor[DW-1];
            neg_r_reg <= dividend[DW-1];
        end
        else if (busy_reg)
        begin
            // restoring step: remainder stays below the divisor
            if (!diff[DW])
            begin
                rem_reg <= diff[DW-1:0];
                quo_reg <= {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[DW-1:0];
                quo_reg <= {quo_reg[DW-2:0], 1'b0};
            end
        end
    end

    assign busy      = busy_reg;
    assign quotient  = neg_q_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign remainder = neg_r_reg ? (~rem_reg + 1'b1) : rem_reg;

endmodule

`default_nettype wire

>>> sv/pse_datapath.sv
// pse_datapath: operand stack memory, top-of-stack register, operator logic,
// result registers; instantiates pse_divider and uses pse_pkg
`default_nettype none

module pse_datapath
#(
    parameter int STACK_DEPTH = 64
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic [1:0]                          req_type,
    input  wire logic signed [pse_pkg::DATA_W-1:0]   operand_value,
    input  wire logic [3:0]                          op_code,
    input  wire pse_pkg::pse_cmd_t                   cmd,
    output pse_pkg::pse_stat_t                       stat,
    output logic signed [pse_pkg::DATA_W-1:0]        top_value,
    output logic [pse_pkg::COUNT_W-1:0]              stack_count,
    output logic [2:0]                               status
);

    localparam int DW = pse_pkg::DATA_W;
    localparam int CW = pse_pkg::COUNT_W;
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int PW = $clog2(STACK_DEPTH + 1);

    logic [1:0]    req_reg;
    logic [DW-1:0] val_reg;
    logic [3:0]    op_reg;
    logic [PW-1:0] sp_reg;
    logic [DW-1:0] top_reg;
    logic [DW-1:0] rd_data_reg;
    logic [DW-1:0] mem [STACK_DEPTH];

    logic [DW-1:0]       top_value_reg;
    logic [CW-1:0]       stack_count_reg;
    logic [2:0]          status_reg;

    logic [PW-1:0] sp_minus2;
    logic [AW-1:0] rd_addr;
    logic          unary;
    logic          div_op;
    logic [PW-1:0] need;
    logic [PW-1:0] base;
    logic [DW-1:0] lhs;
    logic [DW-1:0] rhs;
    logic [DW-1:0] alu_res;
    logic [DW-1:0] op_res;
    logic [2:0]    st;
    logic [PW-1:0] sp_new;
    logic [DW-1:0] top_new;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [DW-1:0] wr_data;
    logic          div_busy;
    logic [DW-1:0] div_quo;
    logic [DW-1:0] div_rem;

    // second entry from the top comes out of memory, top lives in top_reg
    assign sp_minus2 = sp_reg - PW'(2);
    assign rd_addr   = sp_minus2[AW-1:0];
    assign lhs       = rd_data_reg;
    assign rhs       = top_reg;

    assign unary  = (op_reg < pse_pkg::OP_MUL);
    assign div_op = (op_reg == pse_pkg::OP_DIV) || (op_reg == pse_pkg::OP_MOD);
    assign need   = unary ? PW'(1) : PW'(2);
    assign base   = sp_reg - need;

    always_comb
    begin
        case (op_reg)
            pse_pkg::OP_PLUS: alu_res = rhs;
            pse_pkg::OP_NEG:  alu_res = ~rhs + 1'b1;
            pse_pkg::OP_LNOT: alu_res = DW'(rhs == '0);
            pse_pkg::OP_BNOT: alu_res = ~rhs;
            pse_pkg::OP_MUL:  alu_res = lhs * rhs;
            pse_pkg::OP_ADD:  alu_res = lhs + rhs;
            pse_pkg::OP_SUB:  alu_res = lhs - rhs;
            pse_pkg::OP_SHL:  alu_res = lhs << rhs[4:0];
            pse_pkg::OP_SHR:  alu_res = DW'($signed(lhs) >>> rhs[4:0]);
            pse_pkg::OP_AND:  alu_res = lhs & rhs;
            pse_pkg::OP_XOR:  alu_res = lhs ^ rhs;
            pse_pkg::OP_OR:   alu_res = lhs | rhs;
            pse_pkg::OP_LAND: alu_res = DW'((lhs != '0) && (rhs != '0));
            pse_pkg::OP_LOR:  alu_res = DW'((lhs != '0) || (rhs != '0));
            default:          alu_res = '0;
        endcase
    end

    always_comb
    begin
        if (op_reg == pse_pkg::OP_DIV)
        begin
            op_res = div_quo;
        end
        else if (op_reg == pse_pkg::OP_MOD)
        begin
            op_res = div_rem;
        end
        else
        begin
            op_res = alu_res;
        end
    end

    always_comb
    begin
        st = pse_pkg::STATUS_OK;
        unique case (req_reg)
            pse_pkg::REQ_PUSH:
            begin
                if (sp_reg == PW'(STACK_DEPTH))
                begin
                    st = pse_pkg::STATUS_OVER;
                end
            end
            pse_pkg::REQ_APPLY:
            begin
                if (sp_reg < need)
                begin
                    st = pse_pkg::STATUS_UNDER;
                end
                else if (div_op && (rhs == '0))
                begin
                    st = pse_pkg::STATUS_DIVZERO;
                end
                else if (div_op && (lhs == pse_pkg::DATA_MIN) && (rhs == pse_pkg::DATA_ONES))
                begin
                    st = pse_pkg::STATUS_DIVOVF;
                end
            end
            default:
            begin
                st = pse_pkg::STATUS_OK;
            end
        endcase
    end

    always_comb
    begin
        sp_new  = sp_reg;
        top_new = top_reg;
        wr_en   = 1'b0;
        wr_addr = sp_reg[AW-1:0];
        wr_data = val_reg;
        unique case (req_reg)
            pse_pkg::REQ_CLEAR:
            begin
                sp_new = '0;
            end
            pse_pkg::REQ_PUSH:
            begin
                if (st == pse_pkg::STATUS_OK)
                begin
                    wr_en   = 1'b1;
                    top_new = val_reg;
                    sp_new  = sp_reg + 1'b1;
                end
            end
            pse_pkg::REQ_APPLY:
            begin
                if (st == pse_pkg::STATUS_OK)
                begin
                    wr_en   = 1'b1;
                    wr_addr = base[AW-1:0];
                    wr_data = op_res;
                    top_new = op_res;
                    sp_new  = base + 1'b1;
                end
            end
            default:
            begin
                sp_new = sp_reg;
            end
        endcase
    end

    pse_divider u_divider
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (lhs),
        .divisor   (rhs),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign stat.div_ok   = (req_reg == pse_pkg::REQ_APPLY) && div_op && (st == pse_pkg::STATUS_OK);
    assign stat.div_busy = div_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg <= '0;
        end
        else if (cmd.commit)
        begin
            sp_reg <= sp_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req_type;
            val_reg <= operand_value;
            op_reg  <= op_code;
        end
        if (cmd.commit)
        begin
            top_reg         <= top_new;
            top_value_reg   <= (sp_new == '0) ? '0 : top_new;
            stack_count_reg <= CW'(sp_new);
            status_reg      <= st;
        end
    end

    // stack memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.commit && wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign top_value   = top_value_reg;
    assign stack_count = stack_count_reg;
    assign status      = status_reg;

`ifndef SYNTHESIS
    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= PW'(STACK_DEPTH))
        else $error("stack pointer beyond depth");

    a_err_keeps_sp: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && (st != pse_pkg::STATUS_OK)) |=> $stable(sp_reg))
        else $error("failed item changed the stack pointer");
`endif

endmodule

`default_nettype wire

>>> sv/pse_ctrl.sv
// pse_ctrl: sequencing state machine for the postfix stack evaluator
// drives datapath commands and the output valid; uses pse_pkg
`default_nettype none

module pse_ctrl
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output pse_pkg::pse_cmd_t        cmd,
    input  wire pse_pkg::pse_stat_t  stat
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIVIDE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    // result register can take a new item
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.div_ok)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIVIDE;
                end
                else if (out_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_DIVIDE:
            begin
                if (!stat.div_busy && out_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> out_free)
        else $error("result register overwritten while held");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_EXEC))
        else $error("accepted item not executed");

    a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> stat.div_busy)
        else $error("divider did not start");
`endif

endmodule

`default_nettype wire

>>> sv/postfix_stack_evaluator_unit.sv
// postfix_stack_evaluator_unit: evaluates postfix integer expressions on an operand stack.
// Input channel (in_valid/in_stall) takes one item: req_type clears the stack, pushes
// operand_value or applies operator op_code to the top entries.
// Output channel (out_valid/out_stall) gives one item per input item: top_value (zero if
// the stack is empty), stack_count and status (ok, underflow, overflow, divide by zero,
// division overflow). A failed item leaves the stack as it was.
// Clear, push and all operators except div and mod are loaded, executed and committed to
// the output register; div and mod first wait for the one-bit-per-cycle divider.
// One item is in work at a time and is committed before the next is taken. A new item
// is taken while the previous result still waits on a stalled receiver; the block holds
// the next result until the output register frees.
// The second stack entry is read from the stack memory through a registered port; the
// top entry is kept in a register.
// Reset clears the stack pointer and the output valid and leaves the input open; the
// stack memory is not cleared, entries are always written before they are read.
// uses pse_pkg, pse_ctrl, pse_datapath
`default_nettype none

module postfix_stack_evaluator_unit
#(
    parameter int STACK_DEPTH = 64
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [1:0]                          req_type,
    input  wire logic signed [pse_pkg::DATA_W-1:0]   operand_value,
    input  wire logic [3:0]                          op_code,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic signed [pse_pkg::DATA_W-1:0]        top_value,
    output logic [pse_pkg::COUNT_W-1:0]              stack_count,
    output logic [2:0]                               status
);

    pse_pkg::pse_cmd_t  cmd;
    pse_pkg::pse_stat_t stat;

    pse_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    pse_datapath
    #(
        .STACK_DEPTH (STACK_DEPTH)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_type      (req_type),
        .operand_value (operand_value),
        .op_code       (op_code),
        .cmd           (cmd),
        .stat          (stat),
        .top_value     (top_value),
        .stack_count   (stack_count),
        .status        (status)
    );

endmodule

`default_nettype wire
